>>> rtl/lbbm_pkg.sv
// shared types, constants and register map for the led breathe/blink mode controller
// no dependencies
package lbbm_pkg;

  // apb register map: register i at byte address 4*i
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_PRESSED_LEVEL = 3'd0;
  localparam logic [IDX_W-1:0] REG_DEBOUNCE_MS   = 3'd1;
  localparam logic [IDX_W-1:0] REG_LOCK_MS       = 3'd2;
  localparam logic [IDX_W-1:0] REG_BLINK_HALF_MS = 3'd3;
  localparam logic [IDX_W-1:0] REG_BREATH_MIN    = 3'd4;
  localparam logic [IDX_W-1:0] REG_BREATH_MAX    = 3'd5;
  localparam logic [IDX_W-1:0] REG_BREATH_STEP   = 3'd6;
  localparam logic [IDX_W-1:0] REG_EDGE_HOLD_MS  = 3'd7;

  // register reset values
  localparam logic        RST_PRESSED_LEVEL = 1'b1;
  localparam logic [15:0] RST_DEBOUNCE_MS   = 16'd30;
  localparam logic [15:0] RST_LOCK_MS       = 16'd80;
  localparam logic [15:0] RST_BLINK_HALF_MS = 16'd500;
  localparam logic [9:0]  RST_BREATH_MIN    = 10'd20;
  localparam logic [9:0]  RST_BREATH_MAX    = 10'd900;
  localparam logic [9:0]  RST_BREATH_STEP   = 10'd8;
  localparam logic [15:0] RST_EDGE_HOLD_MS  = 16'd500;

  // breathing tick period and the full and off blink duties
  localparam logic [31:0] TICK_MS   = 32'd20;
  localparam logic [9:0]  FULL_DUTY = 10'd1000;
  localparam logic [9:0]  OFF_DUTY  = 10'd0;

  typedef struct packed {
    logic        pressed_level;
    logic [15:0] debounce_ms;
    logic [15:0] lock_ms;
    logic [15:0] blink_half_ms;
    logic [9:0]  breath_min;
    logic [9:0]  breath_max;
    logic [9:0]  breath_step;
    logic [15:0] edge_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [9:0] led_duty;
    logic       duty_written;
    logic       led_mode;
  } step_res_t;

endpackage

>>> rtl/lbbm_regs.sv
// apb configuration register file
// depends on lbbm_pkg
module lbbm_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lbbm_pkg::ADDR_W-1:0] paddr,
  input  logic [lbbm_pkg::DATA_W-1:0] pwdata,
  output logic [lbbm_pkg::DATA_W-1:0] prdata,
  output lbbm_pkg::cfg_t              cfg
);

  logic                       wr_en;
  logic [lbbm_pkg::IDX_W-1:0] idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[lbbm_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pressed_level <= lbbm_pkg::RST_PRESSED_LEVEL;
      cfg.debounce_ms   <= lbbm_pkg::RST_DEBOUNCE_MS;
      cfg.lock_ms       <= lbbm_pkg::RST_LOCK_MS;
      cfg.blink_half_ms <= lbbm_pkg::RST_BLINK_HALF_MS;
      cfg.breath_min    <= lbbm_pkg::RST_BREATH_MIN;
      cfg.breath_max    <= lbbm_pkg::RST_BREATH_MAX;
      cfg.breath_step   <= lbbm_pkg::RST_BREATH_STEP;
      cfg.edge_hold_ms  <= lbbm_pkg::RST_EDGE_HOLD_MS;
    end else if (wr_en) begin
      case (idx)
        lbbm_pkg::REG_PRESSED_LEVEL: cfg.pressed_level <= pwdata[0];
        lbbm_pkg::REG_DEBOUNCE_MS:   cfg.debounce_ms   <= pwdata[15:0];
        lbbm_pkg::REG_LOCK_MS:       cfg.lock_ms       <= pwdata[15:0];
        lbbm_pkg::REG_BLINK_HALF_MS: cfg.blink_half_ms <= pwdata[15:0];
        lbbm_pkg::REG_BREATH_MIN:    cfg.breath_min    <= pwdata[9:0];
        lbbm_pkg::REG_BREATH_MAX:    cfg.breath_max    <= pwdata[9:0];
        lbbm_pkg::REG_BREATH_STEP:   cfg.breath_step   <= pwdata[9:0];
        lbbm_pkg::REG_EDGE_HOLD_MS:  cfg.edge_hold_ms  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      lbbm_pkg::REG_PRESSED_LEVEL: prdata = 32'(cfg.pressed_level);
      lbbm_pkg::REG_DEBOUNCE_MS:   prdata = 32'(cfg.debounce_ms);
      lbbm_pkg::REG_LOCK_MS:       prdata = 32'(cfg.lock_ms);
      lbbm_pkg::REG_BLINK_HALF_MS: prdata = 32'(cfg.blink_half_ms);
      lbbm_pkg::REG_BREATH_MIN:    prdata = 32'(cfg.breath_min);
      lbbm_pkg::REG_BREATH_MAX:    prdata = 32'(cfg.breath_max);
      lbbm_pkg::REG_BREATH_STEP:   prdata = 32'(cfg.breath_step);
      lbbm_pkg::REG_EDGE_HOLD_MS:  prdata = 32'(cfg.edge_hold_ms);
      default:                     prdata = '0;
    endcase
  end

endmodule

>>> rtl/lbbm_press.sv
// button debounce, lockout and accepted-switch counter
// depends on lbbm_pkg
module lbbm_press (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  logic [31:0]    now_time,
  input  logic           irq_seen,
  input  logic           button_level,
  input  lbbm_pkg::cfg_t cfg,
  output logic           accept,
  output logic [31:0]    count_next
);

  logic        debounce_pending;
  logic [31:0] press_time;
  logic [31:0] last_switch_time;
  logic [31:0] switch_total;

  logic        pend;
  logic [31:0] ptime;
  logic        sample;
  logic        pending_next;

  // an edge restarts the wait at this poll
  assign pend   = irq_seen || debounce_pending;
  assign ptime  = irq_seen ? now_time : press_time;
  assign sample = pend && ((now_time - ptime) >= 32'(cfg.debounce_ms));
  assign pending_next = pend && !sample;

  assign accept = sample && (button_level == cfg.pressed_level)
                  && ((now_time - last_switch_time) >= 32'(cfg.lock_ms));
  assign count_next = accept ? switch_total + 32'd1 : switch_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_pending <= 1'b0;
      press_time       <= '0;
      last_switch_time <= '0;
      switch_total     <= '0;
    end else if (fire) begin
      debounce_pending <= pending_next;
      press_time       <= ptime;
      switch_total     <= count_next;
      if (accept) begin
        last_switch_time <= now_time;
      end
    end
  end

endmodule

>>> rtl/lbbm_duty.sv
// mode bit, breathing ramp and blink toggle; produces duty and written flag
// depends on lbbm_pkg
module lbbm_duty (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [31:0]         now_time,
  input  logic                accept,
  input  lbbm_pkg::cfg_t      cfg,
  output lbbm_pkg::step_res_t res
);

  logic        mode_bit;
  logic [9:0]  duty_level;
  logic        ramp_down;
  logic [31:0] last_ramp_time;
  logic [31:0] hold_end_time;
  logic        blink_on;
  logic [31:0] last_toggle_time;

  logic        mode_next;
  logic [9:0]  duty_a;
  logic        down_a;
  logic [31:0] ramp_a;
  logic [31:0] hold_a;
  logic        enter_breath;

  logic        breath_tick;
  logic        breath_step_go;
  logic        [31:0] hold_diff;
  logic signed [11:0] d_raw;
  logic signed [11:0] max_s;
  logic signed [11:0] min_s;
  logic        [31:0] hold_new;

  logic [9:0]  duty_level_next;
  logic        ramp_down_next;
  logic [31:0] last_ramp_time_next;
  logic [31:0] hold_end_time_next;
  logic        blink_tick;
  logic        blink_on_next;
  logic [31:0] last_toggle_time_next;

  assign mode_next    = mode_bit ^ accept;
  assign enter_breath = accept && !mode_next;

  // entering breathing restarts the ramp from the minimum with a hold
  assign hold_new = now_time + 32'(cfg.edge_hold_ms);
  assign duty_a   = enter_breath ? cfg.breath_min : duty_level;
  assign down_a   = enter_breath ? 1'b0 : ramp_down;
  assign ramp_a   = enter_breath ? now_time : last_ramp_time;
  assign hold_a   = enter_breath ? hold_new : hold_end_time;

  assign breath_tick    = !mode_next && ((now_time - ramp_a) >= lbbm_pkg::TICK_MS);
  assign hold_diff      = now_time - hold_a;
  assign breath_step_go = breath_tick && !hold_diff[31];

  assign d_raw = down_a ? $signed({2'b00, duty_a}) - $signed({2'b00, cfg.breath_step})
                        : $signed({2'b00, duty_a}) + $signed({2'b00, cfg.breath_step});
  assign max_s = $signed({2'b00, cfg.breath_max});
  assign min_s = $signed({2'b00, cfg.breath_min});

  always_comb begin
    duty_level_next     = duty_a;
    ramp_down_next      = down_a;
    hold_end_time_next  = hold_a;
    last_ramp_time_next = breath_tick ? now_time : ramp_a;
    if (breath_step_go) begin
      if (d_raw >= max_s) begin
        duty_level_next    = cfg.breath_max;
        ramp_down_next     = 1'b1;
        hold_end_time_next = hold_new;
      end else if (d_raw <= min_s) begin
        duty_level_next    = cfg.breath_min;
        ramp_down_next     = 1'b0;
        hold_end_time_next = hold_new;
      end else begin
        duty_level_next    = d_raw[9:0];
      end
    end
  end

  // any switch clears blink and restarts its timer
  always_comb begin
    blink_on_next         = accept ? 1'b0 : blink_on;
    last_toggle_time_next = accept ? now_time : last_toggle_time;
    blink_tick = mode_next
                 && ((now_time - last_toggle_time_next) >= 32'(cfg.blink_half_ms));
    if (blink_tick) begin
      blink_on_next         = !blink_on_next;
      last_toggle_time_next = now_time;
    end
  end

  always_comb begin
    res.led_mode      = mode_next;
    res.duty_written  = accept || breath_step_go || blink_tick;
    if (mode_next) begin
      res.led_duty = blink_on_next ? lbbm_pkg::FULL_DUTY : lbbm_pkg::OFF_DUTY;
    end else begin
      res.led_duty = duty_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_bit         <= 1'b0;
      duty_level       <= lbbm_pkg::RST_BREATH_MIN;
      ramp_down        <= 1'b0;
      last_ramp_time   <= '0;
      hold_end_time    <= 32'(lbbm_pkg::RST_EDGE_HOLD_MS);
      blink_on         <= 1'b0;
      last_toggle_time <= '0;
    end else if (fire) begin
      mode_bit         <= mode_next;
      duty_level       <= duty_level_next;
      ramp_down        <= ramp_down_next;
      last_ramp_time   <= last_ramp_time_next;
      hold_end_time    <= hold_end_time_next;
      blink_on         <= blink_on_next;
      last_toggle_time <= last_toggle_time_next;
    end
  end

endmodule

>>> rtl/led_breathe_blink_mode_controller_unit.sv
// top level of the led breathe/blink mode controller: input register, step logic, result register
// depends on lbbm_pkg, lbbm_regs, lbbm_press, lbbm_duty
//
// usage
// - input channel (in_valid/in_ready) takes one poll word: now_time in ms, irq_seen
//   (button edge since last poll) and button_level (raw pin)
// - output channel (out_valid/out_ready) gives one result word per poll: led_duty,
//   duty_written, led_mode (0 breathing, 1 blink) and switch_cnt
// - apb port holds eight registers at byte address 4*i; pready is tied high, writes
//   land on the access cycle; write only while no poll is in flight
// - a word accepted into the input register moves into the result register, which drives
//   out_valid, as soon as the output register is free
// - throughput: one word per cycle while results are taken; the state update is a single
//   pass of compares and 32-bit adds between the input register and the result register
// - when the receiver stalls the result register holds its word, the input register
//   keeps one more word, and in_ready drops only when both are full
// - reset (rst, synchronous) empties both registers, loads register defaults and
//   returns the state to breathing mode at the minimum duty with a hold to 500 ms
module led_breathe_blink_mode_controller_unit (
  input  logic                        clk,
  input  logic                        rst,
  // apb configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lbbm_pkg::ADDR_W-1:0] paddr,
  input  logic [lbbm_pkg::DATA_W-1:0] pwdata,
  output logic [lbbm_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  // poll input
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [31:0]                 now_time,
  input  logic                        irq_seen,
  input  logic                        button_level,
  // result output
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [9:0]                  led_duty,
  output logic                        duty_written,
  output logic                        led_mode,
  output logic [31:0]                 switch_cnt
);

  lbbm_pkg::cfg_t      cfg;
  lbbm_pkg::step_res_t step_res;

  // input register
  logic        stage_valid;
  logic [31:0] stage_now;
  logic        stage_irq;
  logic        stage_level;

  logic        out_free;
  logic        fire;
  logic        press_accept;
  logic [31:0] count_next;

  assign pready   = 1'b1;
  assign out_free = !out_valid || out_ready;
  // the staged word moves into the result register and updates the state
  assign fire     = stage_valid && out_free;
  assign in_ready = !stage_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_now   <= now_time;
      stage_irq   <= irq_seen;
      stage_level <= button_level;
    end
  end

  lbbm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  lbbm_press u_press (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .now_time     (stage_now),
    .irq_seen     (stage_irq),
    .button_level (stage_level),
    .cfg          (cfg),
    .accept       (press_accept),
    .count_next   (count_next)
  );

  lbbm_duty u_duty (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .now_time (stage_now),
    .accept   (press_accept),
    .cfg      (cfg),
    .res      (step_res)
  );

  // result register; mode and count start at their reset state so that
  // consecutive results can be compared from the first one on
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      led_mode   <= 1'b0;
      switch_cnt <= '0;
    end else begin
      if (out_free) begin
        out_valid <= stage_valid;
      end
      if (fire) begin
        led_mode   <= step_res.led_mode;
        switch_cnt <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      led_duty     <= step_res.led_duty;
      duty_written <= step_res.duty_written;
    end
  end

  // an accepted press always writes the duty
  a_accept_writes: assert property (@(posedge clk) disable iff (rst)
    fire && press_accept |-> step_res.duty_written)
    else $error("accepted press did not write duty");

  // mode flips exactly when the switch count moves
  a_mode_count: assert property (@(posedge clk) disable iff (rst)
    fire |-> ((step_res.led_mode != led_mode) == (count_next != switch_cnt)))
    else $error("mode change and switch count disagree");

  // blink mode only shows full or off duty
  a_blink_duty: assert property (@(posedge clk) disable iff (rst)
    fire && step_res.led_mode |->
      (step_res.led_duty == lbbm_pkg::FULL_DUTY)
      || (step_res.led_duty == lbbm_pkg::OFF_DUTY))
    else $error("blink duty neither full nor off");

  // a held result with a full input register blocks new words
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    stage_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while both registers full");

endmodule

>>> dv/tb.sv
// testbench for the led breathe/blink mode controller: a directed poll table, then randomized phases
// every result word is checked against a typed-in row result or an in-bench model of the debounce, mode and duty logic
// depends on lbbm_pkg and led_breathe_blink_mode_controller_unit
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // generous bound on the length of a correct run
  localparam int unsigned CYCLE_LIMIT = 400000;
  // receiver hold-off long enough to fill both registers of the block
  localparam int unsigned LONG_HOLD   = 300;

  localparam logic MODE_BREATHE = 1'b0;
  localparam logic MODE_BLINK   = 1'b1;

  // one poll word on the input channel
  typedef struct packed {
    logic [31:0] now_ms;
    logic        irq;
    logic        level;
  } poll_word_t;

  // one result word on the output channel
  typedef struct packed {
    logic [9:0]  duty;
    logic        written;
    logic        mode;
    logic [31:0] count;
  } led_word_t;

  // directed row: the poll, and a typed-in result where it is obvious
  typedef struct packed {
    poll_word_t poll;
    logic       fixed;
    led_word_t  want;
  } poll_row_t;

  logic                          clk;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [lbbm_pkg::ADDR_W-1:0]   paddr;
  logic [lbbm_pkg::DATA_W-1:0]   pwdata;
  logic [lbbm_pkg::DATA_W-1:0]   prdata;
  logic                          pready;
  logic                          in_valid;
  logic                          in_ready;
  logic [31:0]                   now_time;
  logic                          irq_seen;
  logic                          button_level;
  logic                          out_valid;
  logic                          out_ready;
  logic [9:0]                    led_duty;
  logic                          duty_written;
  logic                          led_mode;
  logic [31:0]                   switch_cnt;

  led_breathe_blink_mode_controller_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .now_time     (now_time),
    .irq_seen     (irq_seen),
    .button_level (button_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .led_duty     (led_duty),
    .duty_written (duty_written),
    .led_mode     (led_mode),
    .switch_cnt   (switch_cnt)
  );

  // copy of the registers as the block should hold them
  lbbm_pkg::cfg_t ctrl_regs;

  // controller state mirrored in the bench
  logic        db_wait;
  logic [31:0] press_ms;
  logic [31:0] switched_ms;
  logic [31:0] switch_total;
  logic        mode_now;
  logic [9:0]  duty_now;
  logic        ramp_falling;
  logic [31:0] last_ramp_ms;
  logic [31:0] hold_end_ms;
  logic        blink_lit;
  logic [31:0] toggled_ms;

  // result words still owed by the block, oldest first
  led_word_t   words_due[$];
  poll_row_t   poll_rows[$];

  int unsigned mismatch_count = 0;
  int unsigned cycles_run     = 0;
  int unsigned tx_idle_pct    = 0;
  int unsigned rx_stall_pct   = 0;
  int unsigned rx_hold_req    = 0;
  int unsigned rx_hold_left   = 0;
  int unsigned press_left     = 0;
  logic [31:0] ms_now;

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  // elapsed time modulo 2^32
  function automatic logic [31:0] since(input logic [31:0] later, input logic [31:0] earlier);
    return later - earlier;
  endfunction

  // one poll of the controller: debounce, lockout, mode switch, ramp or blink
  task automatic advance_led_state(input poll_word_t w, output led_word_t r);
    logic [31:0] t;
    logic [31:0] hold_gap;
    logic        wr;
    int          d;
    int          step_i;
    int          min_i;
    int          max_i;
    t  = w.now_ms;
    wr = 1'b0;

    // an edge (re)starts the debounce wait
    if (w.irq) begin
      db_wait  = 1'b1;
      press_ms = t;
    end

    // the level is sampled once when the wait runs out
    if (db_wait && since(t, press_ms) >= ctrl_regs.debounce_ms) begin
      db_wait = 1'b0;
      if (w.level == ctrl_regs.pressed_level && since(t, switched_ms) >= ctrl_regs.lock_ms)
      begin
        switched_ms    = t;
        switch_total   = switch_total + 1;
        mode_now       = ~mode_now;
        blink_lit      = 1'b0;
        toggled_ms     = t;
        if (mode_now == MODE_BREATHE) begin
          duty_now     = ctrl_regs.breath_min;
          ramp_falling = 1'b0;
          last_ramp_ms = t;
          hold_end_ms  = t + ctrl_regs.edge_hold_ms;
        end
        wr = 1'b1;
      end
    end

    if (mode_now == MODE_BREATHE) begin
      if (since(t, last_ramp_ms) >= lbbm_pkg::TICK_MS) begin
        last_ramp_ms = t;
        hold_gap     = since(t, hold_end_ms);
        // ramp pauses while the signed distance to the hold end is negative
        if (!hold_gap[31]) begin
          step_i = ctrl_regs.breath_step;
          min_i  = ctrl_regs.breath_min;
          max_i  = ctrl_regs.breath_max;
          d      = duty_now;
          d      = ramp_falling ? d - step_i : d + step_i;
          // top clamp is tested first, so it wins when min exceeds max
          if (d >= max_i) begin
            d            = max_i;
            ramp_falling = 1'b1;
            hold_end_ms  = t + ctrl_regs.edge_hold_ms;
          end else if (d <= min_i) begin
            d            = min_i;
            ramp_falling = 1'b0;
            hold_end_ms  = t + ctrl_regs.edge_hold_ms;
          end
          duty_now = d[9:0];
          wr       = 1'b1;
        end
      end
    end else begin
      if (since(t, toggled_ms) >= ctrl_regs.blink_half_ms) begin
        toggled_ms     = t;
        blink_lit      = ~blink_lit;
        wr             = 1'b1;
      end
    end

    r.duty    = (mode_now == MODE_BLINK)
                ? (blink_lit ? lbbm_pkg::FULL_DUTY : lbbm_pkg::OFF_DUTY) : duty_now;
    r.written = wr;
    r.mode    = mode_now;
    r.count   = switch_total;
  endtask

  // one apb write; consecutive writes run back to back, load_settings parks the bus
  task automatic write_reg(input logic [lbbm_pkg::IDX_W-1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      lbbm_pkg::REG_PRESSED_LEVEL: ctrl_regs.pressed_level = val[0];
      lbbm_pkg::REG_DEBOUNCE_MS:   ctrl_regs.debounce_ms   = val[15:0];
      lbbm_pkg::REG_LOCK_MS:       ctrl_regs.lock_ms       = val[15:0];
      lbbm_pkg::REG_BLINK_HALF_MS: ctrl_regs.blink_half_ms = val[15:0];
      lbbm_pkg::REG_BREATH_MIN:    ctrl_regs.breath_min    = val[9:0];
      lbbm_pkg::REG_BREATH_MAX:    ctrl_regs.breath_max    = val[9:0];
      lbbm_pkg::REG_BREATH_STEP:   ctrl_regs.breath_step   = val[9:0];
      lbbm_pkg::REG_EDGE_HOLD_MS:  ctrl_regs.edge_hold_ms  = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [31:0] pl, db, lk, bh, bmin, bmax, bstep, hold);
    write_reg(lbbm_pkg::REG_PRESSED_LEVEL, pl);
    write_reg(lbbm_pkg::REG_DEBOUNCE_MS, db);
    write_reg(lbbm_pkg::REG_LOCK_MS, lk);
    write_reg(lbbm_pkg::REG_BLINK_HALF_MS, bh);
    write_reg(lbbm_pkg::REG_BREATH_MIN, bmin);
    write_reg(lbbm_pkg::REG_BREATH_MAX, bmax);
    write_reg(lbbm_pkg::REG_BREATH_STEP, bstep);
    write_reg(lbbm_pkg::REG_EDGE_HOLD_MS, hold);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // offer one poll word, hold it until taken, then log the word it must produce
  task automatic send_poll(input poll_word_t w, input logic fixed, input led_word_t want);
    led_word_t got_model;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    now_time     <= w.now_ms;
    irq_seen     <= w.irq;
    button_level <= w.level;
    do @(posedge clk); while (in_ready !== 1'b1);
    advance_led_state(w, got_model);
    words_due.push_back(fixed ? want : got_model);
  endtask

  // sender stops, waits for every owed word and then idles
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_row(input logic [31:0] t, input logic irq, input logic lvl,
                         input logic fixed, input logic [9:0] duty, input logic wr,
                         input logic mode, input logic [31:0] cnt);
    poll_row_t row;
    row.poll.now_ms  = t;
    row.poll.irq     = irq;
    row.poll.level   = lvl;
    row.fixed        = fixed;
    row.want.duty    = duty;
    row.want.written = wr;
    row.want.mode    = mode;
    row.want.count   = cnt;
    poll_rows.push_back(row);
  endtask

  // random polls: mostly small time steps with press bursts held at the pressed level,
  // some long jumps and some fully random times as noise
  task automatic run_polls(input int unsigned count, input int unsigned dt_max);
    poll_word_t w;
    led_word_t  unused;
    int unsigned roll;
    unused = '0;
    for (int unsigned i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 4) ms_now = $urandom;
      else if (roll < 8) ms_now = ms_now + $urandom_range(0, 70000);
      else ms_now = ms_now + $urandom_range(0, dt_max);
      w.now_ms = ms_now;
      w.irq    = ($urandom_range(99) < 9);
      if (w.irq) press_left = $urandom_range(1, 6);
      if (press_left != 0) begin
        w.level    = ($urandom_range(9) != 0) ? ctrl_regs.pressed_level : ~ctrl_regs.pressed_level;
        press_left = press_left - 1;
      end else begin
        w.level = $urandom_range(1);
      end
      send_poll(w, 1'b0, unused);
    end
  endtask

  // result check: each taken word against the oldest owed one
  always @(posedge clk) begin : result_check
    led_word_t due;
    if (!rst && out_valid && out_ready) begin
      if (words_due.size() == 0) begin
        report_mismatch($sformatf("word with none owed: duty %0d written %0d mode %0d count %0d",
                                  led_duty, duty_written, led_mode, switch_cnt));
      end else begin
        due = words_due.pop_front();
        if (led_duty !== due.duty)
          report_mismatch($sformatf("led_duty %0d, want %0d", led_duty, due.duty));
        if (duty_written !== due.written)
          report_mismatch($sformatf("duty_written %0d, want %0d", duty_written, due.written));
        if (led_mode !== due.mode)
          report_mismatch($sformatf("led_mode %0d, want %0d", led_mode, due.mode));
        if (switch_cnt !== due.count)
          report_mismatch($sformatf("switch_cnt %0d, want %0d", switch_cnt, due.count));
      end
    end
  end

  // receiver: random stalls, or a long hold-off counted down here when asked for
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req != 0) begin
        rx_hold_left = rx_hold_req;
        rx_hold_req  = 0;
      end
      if (rx_hold_left != 0) begin
        rx_hold_left = rx_hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // watchdog
  initial begin
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("tb failed");
    $finish;
  end

  initial begin
    rst          <= 1'b1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_valid     <= 1'b0;
    now_time     <= '0;
    irq_seen     <= 1'b0;
    button_level <= 1'b0;

    // register defaults and post-reset state: breathing at min duty, hold to 500 ms
    ctrl_regs.pressed_level = lbbm_pkg::RST_PRESSED_LEVEL;
    ctrl_regs.debounce_ms   = lbbm_pkg::RST_DEBOUNCE_MS;
    ctrl_regs.lock_ms       = lbbm_pkg::RST_LOCK_MS;
    ctrl_regs.blink_half_ms = lbbm_pkg::RST_BLINK_HALF_MS;
    ctrl_regs.breath_min    = lbbm_pkg::RST_BREATH_MIN;
    ctrl_regs.breath_max    = lbbm_pkg::RST_BREATH_MAX;
    ctrl_regs.breath_step   = lbbm_pkg::RST_BREATH_STEP;
    ctrl_regs.edge_hold_ms  = lbbm_pkg::RST_EDGE_HOLD_MS;
    db_wait        = 1'b0;
    press_ms       = '0;
    switched_ms    = '0;
    switch_total   = '0;
    mode_now       = MODE_BREATHE;
    duty_now       = lbbm_pkg::RST_BREATH_MIN;
    ramp_falling   = 1'b0;
    last_ramp_ms   = '0;
    hold_end_ms    = 32'(lbbm_pkg::RST_EDGE_HOLD_MS);
    blink_lit      = 1'b0;
    toggled_ms     = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed polls at register defaults
    //       time          irq   lvl   fixed duty  wr    mode          count
    add_row(32'd0,        1'b0, 1'b0, 1'b1, 10'd20, 1'b0, MODE_BREATHE, 32'd0); // after reset
    add_row(32'd20,       1'b0, 1'b0, 1'b1, 10'd20, 1'b0, MODE_BREATHE, 32'd0); // hold after reset
    add_row(32'd500,      1'b0, 1'b0, 1'b1, 10'd28, 1'b1, MODE_BREATHE, 32'd0); // first step
    add_row(32'd510,      1'b1, 1'b1, 1'b0, 10'd0,  1'b0, MODE_BREATHE, 32'd0); // edge
    add_row(32'd540,      1'b0, 1'b1, 1'b1, lbbm_pkg::OFF_DUTY, 1'b1, MODE_BLINK,
            32'd1); // enter blink
    add_row(32'd1040,     1'b0, 1'b0, 1'b1, lbbm_pkg::FULL_DUTY, 1'b1, MODE_BLINK,
            32'd1); // blink on
    add_row(32'd1050,     1'b1, 1'b1, 1'b0, 10'd0,  1'b0, MODE_BREATHE, 32'd0);
    add_row(32'd1060,     1'b1, 1'b0, 1'b0, 10'd0,  1'b0, MODE_BREATHE, 32'd0); // edge while waiting
    add_row(32'd1089,     1'b0, 1'b1, 1'b0, 10'd0,  1'b0, MODE_BREATHE, 32'd0); // wait restarted
    add_row(32'd1090,     1'b0, 1'b0, 1'b0, 10'd0,  1'b0, MODE_BREATHE, 32'd0); // released at sample
    add_row(32'd1100,     1'b1, 1'b1, 1'b0, 10'd0,  1'b0, MODE_BREATHE, 32'd0);
    add_row(32'd1130,     1'b0, 1'b1, 1'b1, 10'd20, 1'b1, MODE_BREATHE, 32'd2); // enter breathing
    add_row(32'd1135,     1'b1, 1'b1, 1'b0, 10'd0,  1'b0, MODE_BREATHE, 32'd0);
    add_row(32'd1165,     1'b0, 1'b1, 1'b1, 10'd20, 1'b0, MODE_BREATHE, 32'd2); // within lockout
    add_row(32'd1200,     1'b0, 1'b0, 1'b0, 10'd0,  1'b0, MODE_BREATHE, 32'd0);
    add_row(32'd1630,     1'b0, 1'b0, 1'b0, 10'd0,  1'b0, MODE_BREATHE, 32'd0); // hold ends
    add_row(32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, MODE_BREATHE, 32'd0); // hold reads negative
    add_row(32'h0000_0010, 1'b0, 1'b1, 1'b0, 10'd0, 1'b0, MODE_BREATHE, 32'd0); // time wraps
    add_row(32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 10'd0, 1'b0, MODE_BREATHE, 32'd0);
    add_row(32'h8000_001E, 1'b0, 1'b1, 1'b0, 10'd0, 1'b0, MODE_BREATHE, 32'd0);
    add_row(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 10'd0, 1'b0, MODE_BREATHE, 32'd0); // all-ones time
    add_row(32'h0000_0020, 1'b0, 1'b1, 1'b0, 10'd0, 1'b0, MODE_BREATHE, 32'd0); // debounce over wrap
    add_row(32'h0000_0020, 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, MODE_BREATHE, 32'd0); // same time again
    foreach (poll_rows[i]) send_poll(poll_rows[i].poll, poll_rows[i].fixed, poll_rows[i].want);
    ms_now = poll_rows[poll_rows.size() - 1].poll.now_ms;

    // defaults, no idling on either side
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    run_polls(140, 40);
    wait_drain();

    // low extremes, active-low button, steps that overshoot both ends
    load_settings(32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd1023, 32'd1000, 32'd0);
    tx_idle_pct  = 58;
    rx_stall_pct = 0;
    run_polls(130, 40);
    wait_drain();

    // mid values with frequent clamps and short holds, receiver stalls often
    load_settings(32'd1, 32'd5, 32'd40, 32'd15, 32'd100, 32'd300, 32'd37, 32'd60);
    tx_idle_pct  = 0;
    rx_stall_pct = 58;
    run_polls(130, 40);
    wait_drain();

    // high extremes, min above max, zero step, time crossing the 2^32 wrap
    load_settings(32'd1, 32'd65535, 32'd65535, 32'd65535, 32'd900, 32'd100, 32'd0, 32'd65535);
    tx_idle_pct  = 11;
    rx_stall_pct = 11;
    ms_now       = 32'hFFF0_0000;
    run_polls(130, 30000);
    wait_drain();

    // random settings with junk in the unused upper bits
    load_settings($urandom,
                  $urandom & 32'hFFFF_0000 | $urandom_range(0, 60),
                  $urandom & 32'hFFFF_0000 | $urandom_range(0, 150),
                  $urandom & 32'hFFFF_0000 | $urandom_range(0, 100),
                  $urandom & 32'hFFFF_FC00 | $urandom_range(0, 1023),
                  $urandom & 32'hFFFF_FC00 | $urandom_range(0, 1023),
                  $urandom & 32'hFFFF_FC00 | $urandom_range(1, 200),
                  $urandom & 32'hFFFF_0000 | $urandom_range(0, 300));
    tx_idle_pct  = 11;
    rx_stall_pct = 11;
    run_polls(60, 40);
    // receiver holds off while the sender keeps offering, so in_ready must drop
    tx_idle_pct = 0;
    rx_hold_req = LONG_HOLD;
    run_polls(30, 40);
    // sender pauses until every owed word is out
    wait_drain();
    tx_idle_pct = 11;
    run_polls(60, 40);
    wait_drain();

    // zero blink half period toggles every poll; min equals max at full duty
    load_settings(32'd0, 32'd1, 32'd1, 32'd0, 32'd1000, 32'd1000, 32'd1, 32'd1);
    tx_idle_pct  = 58;
    rx_stall_pct = 58;
    run_polls(130, 40);
    wait_drain();

    if (mismatch_count == 0 && words_due.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/lbbm_pkg.sv
rtl/lbbm_regs.sv
rtl/lbbm_press.sv
rtl/lbbm_duty.sv
rtl/led_breathe_blink_mode_controller_unit.sv
dv/tb.sv
